// ----- sv/swg_pkg.sv -----
package swg_pkg;

  // fixed word widths
  localparam int unsigned XW    = 16;  // Q8.8 input words
  localparam int unsigned YW    = 32;  // Q15.16 result word
  localparam int unsigned AxsW  = 11;  // |x| below the clamp limit
  localparam int unsigned SqW   = 22;  // square of that magnitude
  localparam int unsigned AsumW = 24;  // 27*2^18 + x^2
  localparam int unsigned PW    = 34;  // ratio numerator before the 2^15 scale
  localparam int unsigned QuotW = 25;  // quotient bits, one per divider stage
  localparam int unsigned SW    = 26;  // sigmoid in Q.25, range [0, 2^25]
  localparam int unsigned AxauW = 31;  // |x|*|u| <= 2^30
  localparam int unsigned ProdW = AxauW + SW;

  // pipeline depth: front end, divider, back end
  localparam int unsigned FrontLat = 3;
  localparam int unsigned BackLat  = 3;
  localparam int unsigned Latency  = FrontLat + QuotW + BackLat;

  // Pade constants
  localparam logic [22:0]      PadeA      = 23'd7077888;  // 27 * 2^18
  localparam logic [XW-1:0]    ClampLimit = 16'd1536;     // |h| >= 3
  localparam logic [QuotW-1:0] TOne       = 25'h1000000;  // 1.0 in Q.24

  // sideband that rides along the divider
  typedef struct packed {
    logic             last;
    logic             neg_x;
    logic             neg_y;
    logic             clamp;
    logic [AxauW-1:0] axau;
  } side_t;

endpackage

// ----- sv/swiglu_pade_sigmoid_gate.sv -----
// SwiGLU gate with a Pade-approximated sigmoid, one element per word.
// Input channel: a word is taken at a rising edge with start high and busy
// low. busy is always low, so a new word may enter on every cycle.
// The word is in_gate_value (x, signed Q8.8), in_up_value (u, signed Q8.8)
// and in_last_in (end-of-vector flag).
// Result channel: out_valid is high for one cycle with out_gated_result
// (x * sigmoid(x) * u, signed Q15.16, truncated toward zero) and
// out_last_out (copy of the flag). The receiver cannot stall.
// Pipeline: 3 front-end stages (magnitudes, square, Pade numerator and
// denominator), 25 restoring divider stages with one quotient bit each,
// and 3 back-end stages (sigmoid, product, scale and sign).
// Throughput: one word per cycle, results in input order.
// Reset: synchronous, active low; it clears every valid bit, so no result
// leaves the block until the first word accepted after reset comes out.
module swiglu_pade_sigmoid_gate
  import swg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [XW-1:0] in_gate_value,
  input  logic signed [XW-1:0] in_up_value,
  input  logic                 in_last_in,
  output logic                 out_valid,
  output logic signed [YW-1:0] out_gated_result,
  output logic                 out_last_out
);

  logic             accept;
  logic             f_valid, d_valid;
  logic [PW-1:0]    f_num;
  logic [QuotW-1:0] f_den, d_quot;
  side_t            f_side, d_side;
  logic [YW-1:0]    b_result;

  // fully pipelined, never pushes back
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // magnitudes, square, Pade numerator and denominator
  swg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (accept),
    .gate_value (in_gate_value),
    .up_value   (in_up_value),
    .last_in    (in_last_in),
    .out_valid  (f_valid),
    .num_out    (f_num),
    .den_out    (f_den),
    .side_out   (f_side)
  );

  // tanh ratio quotient
  swg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .num_in    (f_num),
    .den_in    (f_den),
    .side_in   (f_side),
    .out_valid (d_valid),
    .quot_out  (d_quot),
    .side_out  (d_side)
  );

  // sigmoid, product and output word
  swg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (d_valid),
    .quot_in    (d_quot),
    .side_in    (d_side),
    .out_valid  (out_valid),
    .result_out (b_result),
    .last_out   (out_last_out)
  );

  assign out_gated_result = b_result;

  // every accepted word yields exactly one result after the fixed latency
  a_lat_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##31 out_valid)
    else $error("accepted word produced no result");

  a_lat_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 31))
    else $error("result without an accepted word");

  // a zero gate gives a zero result
  a_zero_gate: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && ($past(in_gate_value, 31) == 16'sd0)) |-> (out_gated_result == 32'sd0))
    else $error("zero gate gave a nonzero result");

endmodule

// ----- sv/swg_front.sv -----
module swg_front
  import swg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic signed [XW-1:0] gate_value,
  input  logic signed [XW-1:0] up_value,
  input  logic                 last_in,
  output logic                 out_valid,
  output logic [PW-1:0]        num_out,
  output logic [QuotW-1:0]     den_out,
  output side_t                side_out
);

  // stage 1 registers: magnitudes and signs
  logic            v1_r;
  logic [XW-1:0]   ax1_r, au1_r;
  logic            negx1_r, negy1_r, last1_r;
  logic [XW-1:0]   ax_nxt, au_nxt;

  // stage 2 registers: square and |x|*|u|
  logic            v2_r;
  logic [AxsW-1:0] axs2_r;
  logic [SqW-1:0]  sq2_r;
  side_t           side2_r;
  logic            clamp_nxt;
  logic [AxsW-1:0] axs_nxt;
  logic [SqW-1:0]  sq_nxt;
  logic [YW-1:0]   axau_full;

  // stage 3 registers: numerator and denominator
  logic            v3_r;
  logic [PW-1:0]   p3_r;
  logic [QuotW-1:0] d3_r;
  side_t           side3_r;
  logic [AsumW-1:0] asum;
  logic [PW-1:0]   p_nxt;
  logic [QuotW-1:0] d_nxt;

  // magnitudes of the input words
  assign ax_nxt = gate_value[XW-1] ? (~gate_value + 16'd1) : gate_value;
  assign au_nxt = up_value[XW-1]   ? (~up_value + 16'd1)   : up_value;

  // clamp detect and the narrow magnitude fed to the ratio
  assign clamp_nxt = (ax1_r >= ClampLimit);
  assign axs_nxt   = clamp_nxt ? '0 : ax1_r[AxsW-1:0];
  assign sq_nxt    = axs_nxt * axs_nxt;
  assign axau_full = ax1_r * au1_r;

  // numerator h(27+h^2) and denominator 27+9h^2 in raw units
  assign asum  = AsumW'(PadeA) + AsumW'(sq2_r);
  assign p_nxt = PW'(axs2_r) * PW'(asum);
  assign d_nxt = QuotW'(PadeA) + {sq2_r, 3'b000} + QuotW'(sq2_r);

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    ax1_r   <= ax_nxt;
    au1_r   <= au_nxt;
    negx1_r <= gate_value[XW-1];
    negy1_r <= gate_value[XW-1] ^ up_value[XW-1];
    last1_r <= last_in;

    axs2_r        <= axs_nxt;
    sq2_r         <= sq_nxt;
    side2_r.last  <= last1_r;
    side2_r.neg_x <= negx1_r;
    side2_r.neg_y <= negy1_r;
    side2_r.clamp <= clamp_nxt;
    side2_r.axau  <= axau_full[AxauW-1:0];

    p3_r    <= p_nxt;
    d3_r    <= d_nxt;
    side3_r <= side2_r;
  end

  assign out_valid = v3_r;
  assign num_out   = p3_r;
  assign den_out   = d3_r;
  assign side_out  = side3_r;

endmodule

// ----- sv/swg_div_stage.sv -----
module swg_div_stage
  import swg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [QuotW-1:0] rem_in,
  input  logic [QuotW-1:0] qn_in,
  input  logic [QuotW-1:0] den_in,
  input  side_t            side_in,
  output logic             out_valid,
  output logic [QuotW-1:0] rem_out,
  output logic [QuotW-1:0] qn_out,
  output logic [QuotW-1:0] den_out,
  output side_t            side_out
);

  logic             v_r;
  logic [QuotW-1:0] rem_r, qn_r, den_r;
  side_t            side_r;
  logic [QuotW:0]   rs, diff;
  logic             ge;
  logic [QuotW-1:0] rem_nxt, qn_nxt;

  // one restoring step: bring in the next dividend bit, try the subtract
  assign rs      = {rem_in, qn_in[QuotW-1]};
  assign diff    = rs - {1'b0, den_in};
  assign ge      = (rs >= {1'b0, den_in});
  assign rem_nxt = ge ? diff[QuotW-1:0] : rs[QuotW-1:0];
  assign qn_nxt  = {qn_in[QuotW-2:0], ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    qn_r   <= qn_nxt;
    den_r  <= den_in;
    side_r <= side_in;
  end

  assign out_valid = v_r;
  assign rem_out   = rem_r;
  assign qn_out    = qn_r;
  assign den_out   = den_r;
  assign side_out  = side_r;

endmodule

// ----- sv/swg_div.sv -----
module swg_div
  import swg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [PW-1:0]    num_in,
  input  logic [QuotW-1:0] den_in,
  input  side_t            side_in,
  output logic             out_valid,
  output logic [QuotW-1:0] quot_out,
  output side_t            side_out
);

  logic             v_s    [0:QuotW];
  logic [QuotW-1:0] rem_s  [0:QuotW];
  logic [QuotW-1:0] qn_s   [0:QuotW];
  logic [QuotW-1:0] den_s  [0:QuotW];
  side_t            side_s [0:QuotW];

  // dividend is num * 2^15: high part seeds the remainder, low part shifts in
  assign v_s[0]    = in_valid;
  assign rem_s[0]  = QuotW'(num_in[PW-1:10]);
  assign qn_s[0]   = {num_in[9:0], 15'd0};
  assign den_s[0]  = den_in;
  assign side_s[0] = side_in;

  // one quotient bit per stage
  for (genvar i = 0; i < QuotW; i++) begin : g_step
    swg_div_stage u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v_s[i]),
      .rem_in    (rem_s[i]),
      .qn_in     (qn_s[i]),
      .den_in    (den_s[i]),
      .side_in   (side_s[i]),
      .out_valid (v_s[i+1]),
      .rem_out   (rem_s[i+1]),
      .qn_out    (qn_s[i+1]),
      .den_out   (den_s[i+1]),
      .side_out  (side_s[i+1])
    );
  end

  assign out_valid = v_s[QuotW];
  assign quot_out  = qn_s[QuotW];
  assign side_out  = side_s[QuotW];

  // the final remainder must be below the divisor
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    v_s[QuotW] |-> (rem_s[QuotW] < den_s[QuotW]))
    else $error("divider remainder not below divisor");

endmodule

// ----- sv/swg_back.sv -----
module swg_back
  import swg_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [QuotW-1:0] quot_in,
  input  side_t            side_in,
  output logic             out_valid,
  output logic [YW-1:0]    result_out,
  output logic             last_out
);

  // stage 1: clamped ratio to sigmoid
  logic             v1_r;
  logic [SW-1:0]    s1_r;
  logic [AxauW-1:0] axau1_r;
  logic             negy1_r, last1_r;
  logic [QuotW-1:0] mag;
  logic [SW-1:0]    s_nxt;

  // stage 2: full product
  logic             v2_r;
  logic [ProdW-1:0] prod2_r;
  logic             negy2_r, last2_r;

  // stage 3: scale, sign, output word
  logic             v3_r;
  logic [YW-1:0]    y3_r;
  logic             last3_r;
  logic [YW-1:0]    ymag;

  assign mag   = (side_in.clamp || (quot_in > TOne)) ? TOne : quot_in;
  assign s_nxt = side_in.neg_x ? ({1'b0, TOne} - {1'b0, mag})
                               : ({1'b0, TOne} + {1'b0, mag});

  assign ymag = prod2_r[ProdW-1:25];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r    <= s_nxt;
    axau1_r <= side_in.axau;
    negy1_r <= side_in.neg_y;
    last1_r <= side_in.last;

    prod2_r <= ProdW'(axau1_r) * ProdW'(s1_r);
    negy2_r <= negy1_r;
    last2_r <= last1_r;

    y3_r    <= negy2_r ? (~ymag + 32'd1) : ymag;
    last3_r <= last2_r;
  end

  assign out_valid  = v3_r;
  assign result_out = y3_r;
  assign last_out   = last3_r;

  // sigmoid stays within [0, 1]
  a_sig_range: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (s1_r <= 26'h2000000))
    else $error("sigmoid out of range");

endmodule

// ----- bench/swiglu_pade_sigmoid_gate_test.sv -----
`timescale 1ns / 1ps

module swiglu_pade_sigmoid_gate_test
  import swg_pkg::*;
();

  // tanh ratio and sigmoid scaling
  localparam longint unsigned PADE_BIAS   = 64'd27 << 18;
  localparam longint unsigned RATIO_ONE   = 64'd1 << 24;
  localparam longint unsigned CLAMP_MAG   = 64'd1536;
  localparam int              STALL_LIMIT = 2000;

  typedef struct {
    logic signed [YW-1:0] gated;
    logic                 last;
  } gated_word_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic signed [XW-1:0] in_gate_value;
  logic signed [XW-1:0] in_up_value;
  logic                 in_last_in;
  logic                 out_valid;
  logic signed [YW-1:0] out_gated_result;
  logic                 out_last_out;

  gated_word_t gated_expected[$];
  int          mismatches;
  int          quiet_cycles;
  bit          gaps_on;

  swiglu_pade_sigmoid_gate u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_gate_value    (in_gate_value),
    .in_up_value      (in_up_value),
    .in_last_in       (in_last_in),
    .out_valid        (out_valid),
    .out_gated_result (out_gated_result),
    .out_last_out     (out_last_out)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // pade tanh of x/2 in Q.24, clamped to [-1, 1]
  function automatic longint tanh_ratio_q24(logic signed [XW-1:0] x);
    longint          xs;
    longint unsigned ax;
    longint unsigned sq;
    longint unsigned num;
    longint unsigned den;
    longint unsigned mag;
    xs = longint'(x);
    ax = (xs < 0) ? longint'(-xs) : longint'(xs);
    if (ax >= CLAMP_MAG) begin
      mag = RATIO_ONE;
    end else begin
      sq  = ax * ax;
      num = ax * (PADE_BIAS + sq) * 64'd32768;
      den = PADE_BIAS + 64'd9 * sq;
      mag = num / den;
      if (mag > RATIO_ONE) mag = RATIO_ONE;
    end
    return (xs < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  // x * sigmoid(x) * u in Q15.16, truncated toward zero
  function automatic logic signed [YW-1:0] gated_product(logic signed [XW-1:0] x,
                                                         logic signed [XW-1:0] u);
    longint          xs;
    longint          us;
    longint unsigned sig;
    longint unsigned ax;
    longint unsigned au;
    longint unsigned mag;
    longint unsigned y;
    xs  = longint'(x);
    us  = longint'(u);
    sig = longint'(RATIO_ONE) + tanh_ratio_q24(x);
    ax  = (xs < 0) ? longint'(-xs) : longint'(xs);
    au  = (us < 0) ? longint'(-us) : longint'(us);
    mag = (ax * sig * au) >> 25;
    y   = ((xs < 0) != (us < 0)) ? (64'd0 - mag) : mag;
    return y[YW-1:0];
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    mismatches++;
  endtask

  // drive one word and hold it until the block takes it
  task automatic send_word(logic signed [XW-1:0] x, logic signed [XW-1:0] u,
                           logic last);
    gated_word_t w;
    if (gaps_on && $urandom_range(99) < 8) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start         <= 1'b1;
    in_gate_value <= x;
    in_up_value   <= u;
    in_last_in    <= last;
    do @(posedge clk); while (busy);
    w.gated = gated_product(x, u);
    w.last  = last;
    gated_expected.push_back(w);
  endtask

  // compare every result word with the oldest expected one
  always @(posedge clk) begin
    gated_word_t w;
    if (rst_n && out_valid) begin
      if (gated_expected.size() == 0) begin
        report_mismatch("unexpected word", out_gated_result, 0);
      end else begin
        w = gated_expected.pop_front();
        if (out_gated_result !== w.gated)
          report_mismatch("gated_result", out_gated_result, w.gated);
        if (out_last_out !== w.last)
          report_mismatch("last_out", out_last_out, w.last);
      end
    end
  end

  // watchdog on cycles with no word moving either way
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("swiglu_pade_sigmoid_gate_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // full-scale corners of both operands, then a zero gate or a zero up value
  task automatic test_operand_extremes();
    send_word(16'sh7fff, 16'sh7fff, 1'b0);
    send_word(-16'sh8000, -16'sh8000, 1'b1);
    send_word(-16'sh8000, 16'sh7fff, 1'b0);
    send_word(16'sh7fff, -16'sh8000, 1'b1);
    send_word(16'sh0000, 16'sh7fff, 1'b1);
    send_word(16'sh0000, -16'sh8000, 1'b0);
    send_word(16'sh0200, 16'sh0000, 1'b1);
    send_word(-16'sh0200, 16'sh0000, 1'b0);
  endtask

  // gate magnitudes around |h| = 3 where the ratio saturates
  task automatic test_clamp_boundary();
    send_word(16'sd1535, 16'sh7fff, 1'b0);
    send_word(-16'sd1535, 16'sh7fff, 1'b1);
    send_word(16'sd1536, -16'sh8000, 1'b0);
    send_word(-16'sd1536, -16'sh8000, 1'b1);
    send_word(16'sd1537, 16'sh0100, 1'b0);
    send_word(-16'sd1537, 16'sh0100, 1'b1);
  endtask

  // small gates, down to one LSB, where truncation shows
  task automatic test_small_gate();
    send_word(16'sd1, 16'sh7fff, 1'b0);
    send_word(-16'sd1, 16'sh7fff, 1'b1);
    send_word(16'sd256, 16'sd256, 1'b0);
    send_word(-16'sd256, 16'sd256, 1'b1);
    send_word(16'sd3, -16'sd1, 1'b0);
    send_word(-16'sd512, -16'sd777, 1'b1);
  endtask

  // mixed random stream with a gap-free stretch in the middle
  task automatic test_random_stream(int count);
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] u;
    logic                 last;
    for (int i = 0; i < count; i++) begin
      gaps_on = !(i >= count / 3 && i < count / 3 + 400);
      case ($urandom_range(3))
        0: x = XW'($urandom);
        1: x = XW'(int'($urandom_range(3200)) - 1600);
        2: x = XW'(($urandom_range(1) ? 1 : -1) * int'($urandom_range(1528, 1544)));
        default: x = XW'(int'($urandom_range(600)) - 300);
      endcase
      case ($urandom_range(7))
        0: u = 16'sh7fff;
        1: u = -16'sh8000;
        2: u = XW'(int'($urandom_range(512)) - 256);
        default: u = XW'($urandom);
      endcase
      last = ($urandom_range(7) == 0);
      send_word(x, u, last);
    end
  endtask

  initial begin
    mismatches    = 0;
    gaps_on       = 1'b1;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_gate_value <= '0;
    in_up_value   <= '0;
    in_last_in    <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_operand_extremes();
    test_clamp_boundary();
    test_small_gate();
    test_random_stream(1630);

    // drain the pipeline, then watch for stray words
    start <= 1'b0;
    while (gated_expected.size() != 0) @(posedge clk);
    repeat (Latency + 8) @(posedge clk);
    if (gated_expected.size() != 0)
      report_mismatch("words never returned", 0, gated_expected.size());

    if (mismatches == 0) begin
      $display("swiglu_pade_sigmoid_gate_test: clean");
    end else begin
      $display("swiglu_pade_sigmoid_gate_test: errors");
    end
    $finish;
  end

endmodule
